// ===== sv/idr_pkg.sv =====
package idr_pkg;

    localparam logic [63:0] ID_LIMIT            = 64'h0080_0000_0000_0000;
    localparam logic [31:0] FETCH_TIMEOUT_TICKS = 32'd3000;
    localparam logic [31:0] BACKOFF_DEFAULT     = 32'd500;
    localparam logic [55:0] POS_MASK            = 56'hFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_TAKE     = 3'd1,
        CMD_RESPONSE = 3'd2,
        CMD_TICK     = 3'd3,
        CMD_WARM     = 3'd4,
        CMD_SHUTDOWN = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CFG_REJECT = 3'd1,
        ST_DISABLED   = 3'd2,
        ST_NO_ID      = 3'd3,
        ST_SERVER_ERR = 3'd4,
        ST_RANGE_REJ  = 3'd5,
        ST_SURPLUS    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        REG_INITIAL_STEP = 3'd0,
        REG_MIN_STEP     = 3'd1,
        REG_MAX_STEP     = 3'd2,
        REG_PREFETCH     = 3'd3,
        REG_GROW_BELOW   = 3'd4,
        REG_SHRINK_ABOVE = 3'd5,
        REG_BACKOFF_MIN  = 3'd6,
        REG_BACKOFF_MAX  = 3'd7
    } t_reg;

    // Remaining IDs in a range, zero when the range is used up.
    function automatic logic [55:0] rem56(input logic [55:0] pos, input logic [55:0] last);
        return (last > pos) ? (last - pos) : 56'd0;
    endfunction

    // Prefetch threshold: ceil(frac * length / 256), at least one.
    function automatic logic [55:0] thresh(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [8:0] frac);
        logic [63:0] len;
        logic [63:0] t;
        len = (hi > lo) ? (hi - lo) : 64'd0;
        t   = (len * {55'd0, frac} + 64'd255) >> 8;
        return (t == 64'd0) ? 56'd1 : t[55:0];
    endfunction

endpackage

// ===== sv/idr_if.sv =====
interface idr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic        link_ready;
    logic        server_error;
    logic [63:0] range_lo;
    logic [63:0] range_hi;
    modport source (output valid, cmd, link_ready, server_error, range_lo, range_hi,
                    input ready);
    modport sink   (input valid, cmd, link_ready, server_error, range_lo, range_hi,
                    output ready);
endinterface

interface idr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        id_valid;
    logic [54:0] issued_id;
    logic        fetch_valid;
    logic [31:0] fetch_step;
    logic        ready_flag;
    modport source (output valid, status, id_valid, issued_id, fetch_valid, fetch_step,
                    ready_flag, input ready);
    modport sink   (input valid, status, id_valid, issued_id, fetch_valid, fetch_step,
                    ready_flag, output ready);
endinterface

interface idr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/double_buffered_id_range_dispenser.sv =====
// ID range dispenser with a current and a prefetched spare range. The state is
// updated at the clock edge that accepts an item and the result is held in an
// output register, so one item per cycle is taken as long as results are taken
// too. The input is stalled only while the output register holds a result that
// the sink has not yet taken. Configuration writes are always taken and act at
// the next start command. Range requests appear as fetch_valid with fetch_step
// on a result; the matching grant comes back as a range response item.
module double_buffered_id_range_dispenser
    import idr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    idr_in_if.sink        i_in,
    idr_cfg_if.sink       i_cfg,
    idr_out_if.source     o_out
);

    // Configuration registers.
    logic [31:0] r_initial, r_min, r_max, r_grow, r_shrink, r_bmin, r_bmax;
    logic [8:0]  r_frac;

    // Settings latched at start.
    logic [31:0] r_e_min, r_e_max, r_e_grow, r_e_shrink, r_e_bmin, r_e_bmax;
    logic [8:0]  r_e_frac;

    // Dispenser state.
    logic        r_enabled, r_stopped, r_spare_valid, r_in_flight, r_retry_armed;
    logic [55:0] r_cur_pos, r_cur_end, r_cur_thr, r_sp_pos, r_sp_end, r_sp_thr, r_id_ceiling;
    logic [47:0] r_started, r_now;
    logic [31:0] r_step, r_timeout, r_retry_left, r_backoff;

    logic [31:0] n_e_min, n_e_max, n_e_grow, n_e_shrink, n_e_bmin, n_e_bmax;
    logic [8:0]  n_e_frac;
    logic        n_enabled, n_stopped, n_spare_valid, n_in_flight, n_retry_armed;
    logic [55:0] n_cur_pos, n_cur_end, n_cur_thr, n_sp_pos, n_sp_end, n_sp_thr, n_id_ceiling;
    logic [47:0] n_started, n_now;
    logic [31:0] n_step, n_timeout, n_retry_left, n_backoff;

    // Output register.
    logic        r_out_valid;
    logic [2:0]  r_status, n_status;
    logic        r_id_valid, n_id_valid, r_fetch_valid, n_fetch_valid, r_rdy, n_rdy;
    logic [54:0] r_issued, n_issued;
    logic [31:0] r_fetch_step, n_fetch_step;

    logic        accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.id_valid    = r_id_valid;
    assign o_out.issued_id   = r_issued;
    assign o_out.fetch_valid = r_fetch_valid;
    assign o_out.fetch_step  = r_fetch_step;
    assign o_out.ready_flag  = r_rdy;

    // Next state and result for the item at the input.
    always_comb begin
        logic        do_fetch;
        logic        do_retry;
        logic [31:0] mn, mx, bmin, bmax;
        logic [32:0] dbl;
        logic [47:0] lasted;
        logic [63:0] lo, hi;

        n_e_min = r_e_min;  n_e_max = r_e_max;   n_e_grow = r_e_grow;
        n_e_shrink = r_e_shrink; n_e_bmin = r_e_bmin; n_e_bmax = r_e_bmax;
        n_e_frac = r_e_frac;
        n_enabled = r_enabled; n_stopped = r_stopped; n_spare_valid = r_spare_valid;
        n_in_flight = r_in_flight; n_retry_armed = r_retry_armed;
        n_cur_pos = r_cur_pos; n_cur_end = r_cur_end; n_cur_thr = r_cur_thr;
        n_sp_pos = r_sp_pos; n_sp_end = r_sp_end; n_sp_thr = r_sp_thr;
        n_id_ceiling = r_id_ceiling; n_started = r_started; n_now = r_now;
        n_step = r_step; n_timeout = r_timeout; n_retry_left = r_retry_left;
        n_backoff = r_backoff;
        n_status = ST_OK; n_id_valid = 1'b0; n_issued = '0;
        n_fetch_valid = 1'b0; n_fetch_step = '0;
        do_fetch = 1'b0; do_retry = 1'b0;
        mn = (r_min != 32'd0) ? r_min : r_initial;
        mx = (r_max != 32'd0) ? r_max : r_initial;
        bmin = (r_bmin != 32'd0) ? r_bmin : BACKOFF_DEFAULT;
        bmax = (r_bmax < bmin) ? bmin : r_bmax;
        dbl = '0;
        lasted = '0;
        lo = i_in.range_lo;
        hi = i_in.range_hi;

        case (t_cmd'(i_in.cmd))
            CMD_START: begin
                if (r_initial == 32'd0 || mn > r_initial || r_initial > mx ||
                    r_frac == 9'd0 || r_frac > 9'd256 || r_shrink < r_grow) begin
                    n_status = ST_CFG_REJECT;
                end else begin
                    n_stopped = 1'b0; n_spare_valid = 1'b0; n_in_flight = 1'b0;
                    n_retry_armed = 1'b0;
                    n_cur_pos = '0; n_cur_end = '0; n_cur_thr = '0;
                    n_sp_pos = '0; n_sp_end = '0; n_sp_thr = '0;
                    n_started = '0; n_id_ceiling = '0;
                    n_timeout = '0; n_retry_left = '0;
                    n_e_min = mn; n_e_max = mx; n_e_frac = r_frac;
                    n_e_grow = r_grow; n_e_shrink = r_shrink;
                    n_e_bmin = bmin; n_e_bmax = bmax;
                    n_step = r_initial; n_backoff = bmin; n_enabled = 1'b1;
                end
            end
            CMD_TAKE: begin
                if (!r_enabled) begin
                    n_status = ST_DISABLED;
                end else begin
                    // Swap in the spare when the current range is empty.
                    if (rem56(n_cur_pos, n_cur_end) == 56'd0 && n_spare_valid) begin
                        n_cur_pos = r_sp_pos; n_cur_end = r_sp_end; n_cur_thr = r_sp_thr;
                        n_started = r_now;
                        n_sp_pos = '0; n_sp_end = '0; n_sp_thr = '0;
                        n_spare_valid = 1'b0;
                    end
                    if (rem56(n_cur_pos, n_cur_end) != 56'd0) begin
                        n_id_valid = 1'b1;
                        n_issued = n_cur_pos[54:0];
                        n_cur_pos = n_cur_pos + 56'd1;
                        // Adapt the step to how long the range lasted.
                        if (rem56(n_cur_pos, n_cur_end) == 56'd0) begin
                            lasted = r_now - n_started;
                            if ({16'd0, lasted} < {32'd0, r_e_grow}) begin
                                dbl = {r_step, 1'b0};
                                n_step = (dbl > {1'b0, r_e_max}) ? r_e_max : dbl[31:0];
                            end else if ({16'd0, lasted} > {32'd0, r_e_shrink}) begin
                                n_step = ({1'b0, r_step[31:1]} < r_e_min) ? r_e_min
                                                                          : {1'b0, r_step[31:1]};
                            end
                        end
                        do_fetch = !n_spare_valid && !r_in_flight && !r_retry_armed &&
                                   rem56(n_cur_pos, n_cur_end) <= n_cur_thr;
                    end else begin
                        n_status = ST_NO_ID;
                        do_fetch = 1'b1;
                    end
                end
            end
            CMD_RESPONSE: begin
                if (!r_enabled) begin
                    n_status = ST_DISABLED;
                end else begin
                    n_in_flight = 1'b0;
                    if (i_in.server_error) begin
                        n_status = ST_SERVER_ERR;
                        do_retry = 1'b1;
                    end else if (lo == 64'd0 || hi <= lo || hi > ID_LIMIT ||
                                 lo < {8'd0, r_id_ceiling}) begin
                        n_status = ST_RANGE_REJ;
                        do_retry = 1'b1;
                    end else begin
                        n_id_ceiling = hi[55:0];
                        n_backoff = r_e_bmin;
                        if (rem56(r_cur_pos, r_cur_end) == 56'd0 && !r_spare_valid) begin
                            n_cur_pos = lo[55:0]; n_cur_end = hi[55:0];
                            n_cur_thr = thresh(lo, hi, r_e_frac);
                            n_started = r_now;
                        end else if (!r_spare_valid) begin
                            n_sp_pos = lo[55:0]; n_sp_end = hi[55:0];
                            n_sp_thr = thresh(lo, hi, r_e_frac);
                            n_spare_valid = 1'b1;
                        end else begin
                            n_status = ST_SURPLUS;
                        end
                    end
                end
            end
            CMD_TICK: begin
                n_now = r_now + 48'd1;
                if (r_in_flight) begin
                    if (r_timeout > 32'd0) n_timeout = r_timeout - 32'd1;
                    if (n_timeout == 32'd0) begin
                        n_in_flight = 1'b0;
                        do_retry = 1'b1;
                    end
                end else if (r_retry_armed) begin
                    if (r_retry_left > 32'd0) n_retry_left = r_retry_left - 32'd1;
                    if (n_retry_left == 32'd0) begin
                        n_retry_armed = 1'b0;
                        do_fetch = !r_spare_valid && rem56(r_cur_pos, r_cur_end) <= r_cur_thr;
                    end
                end
            end
            CMD_WARM: begin
                if (!r_enabled) begin
                    n_status = ST_DISABLED;
                end else begin
                    do_fetch = !(rem56(r_cur_pos, r_cur_end) != 56'd0 ||
                                 (r_spare_valid && rem56(r_sp_pos, r_sp_end) != 56'd0));
                end
            end
            CMD_SHUTDOWN: begin
                if (!r_enabled) begin
                    n_status = ST_DISABLED;
                end else if (!r_stopped) begin
                    n_stopped = 1'b1;
                    n_retry_armed = 1'b0; n_in_flight = 1'b0;
                    n_retry_left = '0; n_timeout = '0;
                end
            end
            default: begin
            end
        endcase

        // Send a request, or schedule a retry when the link cannot take it.
        if (do_fetch && n_enabled && !n_stopped && !n_in_flight && !n_retry_armed &&
            !n_spare_valid) begin
            if (i_in.link_ready) begin
                n_in_flight = 1'b1;
                n_timeout = FETCH_TIMEOUT_TICKS;
                n_fetch_valid = 1'b1;
                n_fetch_step = n_step;
            end else begin
                do_retry = 1'b1;
            end
        end

        // Retry with doubling delay, capped.
        if (do_retry && !n_stopped && !n_retry_armed) begin
            n_retry_armed = 1'b1;
            n_retry_left = n_backoff;
            dbl = {n_backoff, 1'b0};
            n_backoff = (dbl < {1'b0, n_e_bmax}) ? dbl[31:0] : n_e_bmax;
        end

        n_rdy = n_enabled && (rem56(n_cur_pos, n_cur_end) != 56'd0 ||
                              (n_spare_valid && rem56(n_sp_pos, n_sp_end) != 56'd0));
    end

    // Configuration, state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial <= 32'd1000; r_min <= '0; r_max <= '0; r_frac <= 9'd51;
            r_grow <= 32'd1000; r_shrink <= 32'd60000;
            r_bmin <= BACKOFF_DEFAULT; r_bmax <= 32'd5000;
            r_e_min <= '0; r_e_max <= '0; r_e_grow <= '0; r_e_shrink <= '0;
            r_e_bmin <= '0; r_e_bmax <= '0; r_e_frac <= '0;
            r_enabled <= 1'b0; r_stopped <= 1'b0; r_spare_valid <= 1'b0;
            r_in_flight <= 1'b0; r_retry_armed <= 1'b0;
            r_cur_pos <= '0; r_cur_end <= '0; r_cur_thr <= '0;
            r_sp_pos <= '0; r_sp_end <= '0; r_sp_thr <= '0;
            r_id_ceiling <= '0; r_started <= '0; r_now <= '0;
            r_step <= '0; r_timeout <= '0; r_retry_left <= '0;
            r_backoff <= BACKOFF_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (t_reg'(i_cfg.index))
                    REG_INITIAL_STEP: r_initial <= i_cfg.data;
                    REG_MIN_STEP:     r_min     <= i_cfg.data;
                    REG_MAX_STEP:     r_max     <= i_cfg.data;
                    REG_PREFETCH:     r_frac    <= i_cfg.data[8:0];
                    REG_GROW_BELOW:   r_grow    <= i_cfg.data;
                    REG_SHRINK_ABOVE: r_shrink  <= i_cfg.data;
                    REG_BACKOFF_MIN:  r_bmin    <= i_cfg.data;
                    REG_BACKOFF_MAX:  r_bmax    <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_e_min <= n_e_min; r_e_max <= n_e_max; r_e_grow <= n_e_grow;
                r_e_shrink <= n_e_shrink; r_e_bmin <= n_e_bmin; r_e_bmax <= n_e_bmax;
                r_e_frac <= n_e_frac;
                r_enabled <= n_enabled; r_stopped <= n_stopped;
                r_spare_valid <= n_spare_valid; r_in_flight <= n_in_flight;
                r_retry_armed <= n_retry_armed;
                r_cur_pos <= n_cur_pos; r_cur_end <= n_cur_end; r_cur_thr <= n_cur_thr;
                r_sp_pos <= n_sp_pos; r_sp_end <= n_sp_end; r_sp_thr <= n_sp_thr;
                r_id_ceiling <= n_id_ceiling; r_started <= n_started; r_now <= n_now;
                r_step <= n_step; r_timeout <= n_timeout; r_retry_left <= n_retry_left;
                r_backoff <= n_backoff;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_id_valid    <= n_id_valid;
            r_issued      <= n_issued;
            r_fetch_valid <= n_fetch_valid;
            r_fetch_step  <= n_fetch_step;
            r_rdy         <= n_rdy;
        end
    end

endmodule

// ===== sv/idr_checker.sv =====
module idr_checker
    import idr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        id_valid,
    input logic [54:0] issued_id,
    input logic        fetch_valid,
    input logic [31:0] fetch_step
);

    // An issued ID always comes with an ok status.
    a_id_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && id_valid |-> status == ST_OK)
        else $error("ID issued with a non-ok status");

    // Fields without their valid flag read as zero.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (id_valid || issued_id == '0) && (fetch_valid || fetch_step == '0))
        else $error("payload field set without its flag");

    // An accepted item yields a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(issued_id))
        else $error("stalled result changed");

endmodule

bind double_buffered_id_range_dispenser idr_checker u_idr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_in.valid),
    .in_ready    (i_in.ready),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .status      (o_out.status),
    .id_valid    (o_out.id_valid),
    .issued_id   (o_out.issued_id),
    .fetch_valid (o_out.fetch_valid),
    .fetch_step  (o_out.fetch_step)
);
